FILE: hdl/pp_pkg.sv
// ----------------------------------------------------------------------------
// Pivot partition package
// Store depth, derived widths and the beat types of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pp_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		logic signed [31:0] element;
		logic               last;
	} pp_in_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [CNT_W-1:0]   split_index;
		logic               overflow;
		logic               end_of_batch;
	} pp_out_t;

endpackage

`default_nettype wire

FILE: hdl/pp_engine.sv
// ----------------------------------------------------------------------------
// Pivot partition engine
// Element store, load counter and the sequencer that runs the Lomuto pass
// through a single compare unit and then reads the store out in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pp_engine import pp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire pp_in_t             in_data,
	input  wire logic signed [31:0] pivot,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output pp_out_t                 res_data
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_RD,
		S_CMP,
		S_SWP,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] right_q;
	logic             ovf_q;

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_a_q;
	logic [31:0] rdata_b_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [31:0]      wdata;
	logic             rd_en;
	logic             has_room;
	logic             le;
	logic             last_r;
	logic [CNT_W-1:0] right_inc;

	assign has_room  = fill_q < CNT_W'(DEPTH);
	assign le        = $signed(rdata_a_q) <= pivot;
	assign right_inc = right_q + CNT_W'(1);
	assign last_r    = right_inc == fill_q;
	assign rd_en     = (state_q == S_RD) || (state_q == S_EMIT_RD);
	assign in_stall  = state_q != S_LOAD;

	// single write port: load, then the two halves of a swap
	always_comb begin
		we    = 1'b0;
		waddr = left_q[IDX_W-1:0];
		wdata = rdata_a_q;
		unique case (state_q)
			S_LOAD: begin
				we    = in_valid && has_room;
				waddr = fill_q[IDX_W-1:0];
				wdata = in_data.element;
			end
			S_CMP: begin
				we    = le;
				waddr = left_q[IDX_W-1:0];
				wdata = rdata_a_q;
			end
			S_SWP: begin
				we    = 1'b1;
				waddr = right_q[IDX_W-1:0];
				wdata = rdata_b_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// port A follows the scan index, port B the left index
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_a_q <= mem[right_q[IDX_W-1:0]];
			rdata_b_q <= mem[left_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			fill_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (has_room) begin
							fill_q <= fill_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_data.last) begin
							left_q  <= '0;
							right_q <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (le) begin
						state_q <= S_SWP;
					end else if (last_r) begin
						right_q <= '0;
						state_q <= S_EMIT_RD;
					end else begin
						right_q <= right_inc;
						state_q <= S_RD;
					end
				end
				S_SWP: begin
					left_q <= left_q + CNT_W'(1);
					if (last_r) begin
						right_q <= '0;
						state_q <= S_EMIT_RD;
					end else begin
						right_q <= right_inc;
						state_q <= S_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						if (last_r) begin
							// batch done: rearm for the next load
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							right_q <= right_inc;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign res_valid             = state_q == S_EMIT;
	assign res_data.value        = rdata_a_q;
	assign res_data.split_index  = left_q;
	assign res_data.overflow     = ovf_q;
	assign res_data.end_of_batch = last_r;

endmodule

`default_nettype wire

FILE: hdl/pivot_partition_top.sv
// Load: a beat is taken while the engine loads; the beat with last starts the partition.
// Partition: each stored element is read (S_RD) and compared (S_CMP), with a
// swap (S_SWP) for each one at or below the pivot; one compare unit and one
// memory write port set this. Readout: store read, then present until taken.
// Reset clears the pivot to 0 and empties the store; no clearing pass.
// ----------------------------------------------------------------------------
// Pivot partition top
// Pivot register, engine and the output register toward the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pivot_partition_top import pp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire pp_in_t      in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output pp_out_t          out_data,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	logic signed [31:0] pivot_q;
	logic               out_valid_q;
	pp_out_t            out_data_q;
	logic               res_valid;
	logic               res_ready;
	pp_out_t            res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q <= '0;
		end else if (cfg_wr_en) begin
			pivot_q <= $signed(cfg_wr_data);
		end
	end

	pp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.pivot     (pivot_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// take a new beat when the register is empty or being drained
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_stall)
		else $error("engine loads while emitting");

	a_split_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.split_index <= CNT_W'(DEPTH)))
		else $error("split index beyond store depth");

	a_close_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.last) |=> in_stall)
		else $error("batch close did not start partition");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Pivot partition testbench
// Loads batches through the input channel and checks every partitioned
// result beat against a scoreboard of predicted beats. Covers directed edge
// values, store-full and exact-fill batches, several pivot settings and
// random stalling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import pp_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES  = 100;
	localparam int MAX_REPORTS   = 10;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	pp_in_t            in_data     = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	pp_out_t           out_data;
	logic              cfg_wr_en   = 1'b0;
	logic [31:0]       cfg_wr_data = '0;

	pp_in_t             pending_items[$];
	pp_out_t            expected_beats[$];
	logic signed [31:0] batch_elems[$];
	logic               batch_dropped = 1'b0;
	logic signed [31:0] pivot_shadow  = '0;
	int                 send_idle_pct = 6;
	int                 recv_idle_pct = 76;
	int                 mismatch_count = 0;
	int                 quiet_cycles   = 0;

	pivot_partition_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Store one element; on the closing beat partition and queue the batch.
	function automatic void absorb_element(input pp_in_t item);
		logic signed [31:0] tmp;
		pp_out_t            beat;
		int                 left;
		if (batch_elems.size() < DEPTH)
			batch_elems.push_back(item.element);
		else
			batch_dropped = 1'b1;
		if (!item.last)
			return;
		left = 0;
		for (int r = 0; r < batch_elems.size(); r++) begin
			if (batch_elems[r] <= pivot_shadow) begin
				tmp = batch_elems[left];
				batch_elems[left] = batch_elems[r];
				batch_elems[r] = tmp;
				left++;
			end
		end
		for (int k = 0; k < batch_elems.size(); k++) begin
			beat.value        = batch_elems[k];
			beat.split_index  = CNT_W'(left);
			beat.overflow     = batch_dropped;
			beat.end_of_batch = (k == batch_elems.size() - 1);
			expected_beats.push_back(beat);
		end
		batch_elems.delete();
		batch_dropped = 1'b0;
	endfunction

	// Input driver: hold a stalled beat, otherwise present the next one or idle.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			absorb_element(pending_items.pop_front());
		if (in_valid && in_stall) begin
			// hold beat
		end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			in_valid <= 1'b1;
			in_data  <= pending_items[0];
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result monitor and receiver stall.
	always @(posedge clk) begin : result_check
		pp_out_t want;
		if (out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected beat: value=%0d split=%0d ovf=%0b eob=%0b",
						out_data.value, out_data.split_index, out_data.overflow,
						out_data.end_of_batch);
			end else begin
				want = expected_beats.pop_front();
				if (out_data.value !== want.value ||
						out_data.split_index !== want.split_index ||
						out_data.overflow !== want.overflow ||
						out_data.end_of_batch !== want.end_of_batch) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display(
							"mismatch exp v=%0d s=%0d o=%0b e=%0b, got v=%0d s=%0d o=%0b e=%0b",
							want.value, want.split_index, want.overflow,
							want.end_of_batch, out_data.value, out_data.split_index,
							out_data.overflow, out_data.end_of_batch);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic signed [31:0] pick_element();
		logic signed [31:0] offset;
		offset = $urandom_range(6);
		case ($urandom_range(3))
			0: return pivot_shadow;
			1: return pivot_shadow + offset - 3;
			default: return $urandom();
		endcase
	endfunction

	// Mostly short batches, some medium, some near, at or past the store depth.
	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(1, 8);
		else if (r < 90)
			return $urandom_range(9, 40);
		return $urandom_range(DEPTH - 4, DEPTH + 8);
	endfunction

	task automatic push_item(input logic signed [31:0] elem, input logic last);
		pp_in_t item;
		item.element = elem;
		item.last    = last;
		pending_items.push_back(item);
	endtask

	task automatic queue_batch(input int len);
		for (int i = 0; i < len; i++)
			push_item(pick_element(), i == len - 1);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_beats.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_pivot(input logic signed [31:0] p);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= p;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		pivot_shadow = p;
	endtask

	task automatic run_phase(input logic signed [31:0] p, input int items_wanted,
			input int s_idle, input int r_idle, input bit pause_midway,
			input int lead_len);
		int queued;
		int len;
		// let any work on a trailing beat finish before touching the pivot
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_pivot(p);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		@(negedge clk);
		queued = 0;
		if (lead_len != 0) begin
			queue_batch(lead_len);
			queued += lead_len;
		end
		if (pause_midway) begin
			// open a batch, then hold the sender until all results are out
			len = pick_length();
			queue_batch(len);
			for (int i = 0; i < 3; i++)
				push_item(pick_element(), 1'b0);
			queued += len + 3;
			wait_drained();
			// close the open batch
			len = pick_length();
			queue_batch(len);
			queued += len;
		end
		while (queued < items_wanted) begin
			len = pick_length();
			queue_batch(len);
			queued += len;
		end
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pivot at reset value zero
		push_item(32'sh7FFFFFFF, 1'b0);
		push_item(32'sh80000000, 1'b0);
		push_item(32'sd0, 1'b0);
		push_item(-32'sd1, 1'b0);
		push_item(32'sd1, 1'b0);
		push_item(32'sd0, 1'b0);
		push_item(32'sh80000001, 1'b0);
		push_item(32'sh7FFFFFFE, 1'b1);
		// single-element batches on each side of the pivot
		push_item(32'sd0, 1'b1);
		push_item(32'sd1, 1'b1);
		// all above, then all below
		push_item(32'sd5, 1'b0);
		push_item(32'sd6, 1'b0);
		push_item(32'sd7, 1'b1);
		push_item(-32'sd5, 1'b0);
		push_item(-32'sd6, 1'b0);
		push_item(-32'sd7, 1'b1);
		wait_drained();

		run_phase(32'sh7FFFFFFF, 60, 6, 76, 1'b0, DEPTH + 2);
		run_phase(32'sh80000000, 60, 6, 76, 1'b0, DEPTH);
		run_phase($urandom(), 60, 76, 6, 1'b1, 0);
		run_phase(-32'sd1, 60, 76, 6, 1'b0, DEPTH + 1);
		run_phase($urandom(), 60, 0, 0, 1'b0, 0);
		run_phase(32'sd1, 60, 0, 0, 1'b0, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_beats.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
hdl/pp_pkg.sv
hdl/pp_engine.sv
hdl/pivot_partition_top.sv
tb/tb_top.sv
